>>> sv/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants for the line crossing counter
// Item, command and result formats, operation codes and sizing constants.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int MAX_TRACKS     = 64;
  localparam int COORD_BITS     = 10;
  localparam int COUNT_BITS     = 16;
  localparam int FRAME_BITS     = 10;
  localparam int MODE_BITS      = 2;
  localparam int TRACK_ID_BITS  = 6;

  localparam int SLOT_BITS      = $clog2(MAX_TRACKS);
  localparam int CENTER_BITS    = COORD_BITS + 1;
  localparam int DIFF_BITS      = CENTER_BITS + 1;
  localparam int PROD_BITS      = 2 * DIFF_BITS;
  localparam int TURN_BITS      = PROD_BITS + 1;

  localparam int NUM_LINES      = 3;
  localparam int LINE_HORIZONTAL = 0;
  localparam int LINE_VERTICAL  = 1;
  localparam int LINE_DIAGONAL  = 2;
  localparam int TURNS_PER_LINE = 4;

  localparam int CMDQ_DEPTH     = 4;
  localparam int RESQ_DEPTH     = 4;
  localparam int RESQ_LEVEL_BITS = $clog2(RESQ_DEPTH + 1);

  localparam logic [FRAME_BITS-1:0] FRAME_RESET = FRAME_BITS'(160);

  localparam logic [MODE_BITS-1:0] MODE_UPDATE = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_FORGET = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = MODE_BITS'(2);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_UPDATE,
    OP_FORGET,
    OP_CLEAR,
    OP_IDLE
  } op_t;

  typedef enum logic [1:0] {
    TURN_FLAT,
    TURN_POS,
    TURN_NEG
  } turn_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]     mode;
    logic [TRACK_ID_BITS-1:0] track_id;
    logic [COORD_BITS-1:0]    box_x;
    logic [COORD_BITS-1:0]    box_y;
    logic [COORD_BITS-1:0]    box_w;
    logic [COORD_BITS-1:0]    box_h;
  } item_t;

  typedef struct packed {
    logic                  hit_horizontal;
    logic                  hit_vertical;
    logic                  hit_diagonal;
    logic [COUNT_BITS-1:0] horizontal_total;
    logic [COUNT_BITS-1:0] vertical_total;
    logic [COUNT_BITS-1:0] diagonal_total;
  } result_t;

  typedef struct packed {
    logic [CENTER_BITS-1:0] x;
    logic [CENTER_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    op_t                  op;
    logic [SLOT_BITS-1:0] slot;
    point_t               center;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_push_t;

endpackage

>>> sv/line_crossing_counter_core.sv
// ----------------------------------------------------------------------------
// line_crossing_counter_core: tripwire line crossing counter
// Counts tracked objects whose movement crosses the horizontal, vertical and
// diagonal lines of the frame, one detection request per clock unless full.
// ----------------------------------------------------------------------------
// The block takes one request per clock while full is low and returns one
// result per request, in order. An accepted request waits in the command
// queue, then the registered read of the slot's last center feeds the cross
// products, then the sign tests and the count update are made, after which
// the result waits in the result queue until it is popped. The sustained rate
// of one request per cycle holds while the result queue keeps room; the
// last-center table serves one read and one write per cycle.
// Frame size registers should be written while no request is in flight.
module line_crossing_counter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  lcc_pkg::item_t                 item,
  output logic                           empty,
  input  logic                           pop,
  output lcc_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  lcc_pkg::cfg_reg_t              cfg_index,
  input  logic [lcc_pkg::FRAME_BITS-1:0] cfg_data
);
  import lcc_pkg::*;

  logic [FRAME_BITS-1:0]      frame_width;
  logic [FRAME_BITS-1:0]      frame_height;
  cmd_head_t                  head;
  logic                       head_pop;
  res_push_t                  res_push;
  logic [RESQ_LEVEL_BITS-1:0] res_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_RESET;
      frame_height <= FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  lcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .head     (head),
    .head_pop (head_pop)
  );

  lcc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .head         (head),
    .head_pop     (head_pop),
    .res_level    (res_level),
    .res_push     (res_push)
  );

  lcc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .level    (res_level)
  );

endmodule

>>> sv/lcc_front.sv
// ----------------------------------------------------------------------------
// lcc_front: request intake and classification
// Forms the box center, turns mode and slot into an operation and buffers
// the commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module lcc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  lcc_pkg::item_t     item,
  output lcc_pkg::cmd_head_t head,
  input  logic               head_pop
);
  import lcc_pkg::*;

  localparam int PTR_BITS   = $clog2(CMDQ_DEPTH);
  localparam int LEVEL_BITS = $clog2(CMDQ_DEPTH + 1);

  cmd_t                  cmd_in;
  logic                  in_range;
  logic                  wr_en;
  logic                  rd_en;
  cmd_t                  queue [CMDQ_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS-1:0] level_next;

  always_comb begin
    in_range        = int'(item.track_id) < MAX_TRACKS;
    cmd_in.slot     = SLOT_BITS'(item.track_id);
    cmd_in.center.x = CENTER_BITS'(item.box_x) + CENTER_BITS'(item.box_w >> 1);
    cmd_in.center.y = CENTER_BITS'(item.box_y) + CENTER_BITS'(item.box_h >> 1);
    case (item.mode)
      MODE_UPDATE: begin
        cmd_in.op = in_range ? OP_UPDATE : OP_IDLE;
      end
      MODE_FORGET: begin
        cmd_in.op = in_range ? OP_FORGET : OP_IDLE;
      end
      MODE_CLEAR: begin
        cmd_in.op = OP_CLEAR;
      end
      default: begin
        cmd_in.op = OP_IDLE;
      end
    endcase
  end

  assign full  = level == LEVEL_BITS'(CMDQ_DEPTH);
  assign wr_en = push && !full;
  assign rd_en = head_pop && head.valid;

  assign head.valid = level != '0;
  assign head.cmd   = queue[rd_ptr];

  always_comb begin
    level_next = level;
    if (wr_en && !rd_en) begin
      level_next = level + LEVEL_BITS'(1);
    end else if (rd_en && !wr_en) begin
      level_next = level - LEVEL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      level <= level_next;
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

endmodule

>>> sv/lcc_back.sv
// ----------------------------------------------------------------------------
// lcc_back: per-slot state and segment crossing tests
// Reads and writes the last-center table, forms twelve orientation tests
// against the three frame lines and updates the flags and the counts.
// ----------------------------------------------------------------------------
module lcc_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [lcc_pkg::FRAME_BITS-1:0]       frame_width,
  input  logic [lcc_pkg::FRAME_BITS-1:0]       frame_height,
  input  lcc_pkg::cmd_head_t                   head,
  output logic                                 head_pop,
  input  logic [lcc_pkg::RESQ_LEVEL_BITS-1:0]  res_level,
  output lcc_pkg::res_push_t                   res_push
);
  import lcc_pkg::*;

  function automatic logic signed [DIFF_BITS-1:0] coord_diff(
    input logic [CENTER_BITS-1:0] hi,
    input logic [CENTER_BITS-1:0] lo
  );
    return $signed({1'b0, hi}) - $signed({1'b0, lo});
  endfunction

  function automatic logic in_box(input point_t u, input point_t m, input point_t w);
    logic in_x;
    logic in_y;
    in_x = (m.x >= u.x && m.x <= w.x) || (m.x >= w.x && m.x <= u.x);
    in_y = (m.y >= u.y && m.y <= w.y) || (m.y >= w.y && m.y <= u.y);
    return in_x && in_y;
  endfunction

  // Center table, one entry per slot.
  point_t center_mem [MAX_TRACKS];

  // Stage 1: command plus the slot's previous center.
  logic   s1_valid;
  cmd_t   s1_cmd;
  point_t s1_last;

  // Stage 2: command, endpoints and all products of the orientation tests.
  logic   s2_valid;
  cmd_t   s2_cmd;
  point_t s2_last;
  logic signed [PROD_BITS-1:0] prod_l [NUM_LINES][TURNS_PER_LINE];
  logic signed [PROD_BITS-1:0] prod_r [NUM_LINES][TURNS_PER_LINE];
  logic signed [PROD_BITS-1:0] s2_prod_l [NUM_LINES][TURNS_PER_LINE];
  logic signed [PROD_BITS-1:0] s2_prod_r [NUM_LINES][TURNS_PER_LINE];

  point_t line_p [NUM_LINES];
  point_t line_q [NUM_LINES];

  logic [MAX_TRACKS-1:0] known;
  logic [MAX_TRACKS-1:0] counted;
  logic                  test_en;
  turn_t                 turn [NUM_LINES][TURNS_PER_LINE];
  logic [NUM_LINES-1:0]  hit;
  logic [COUNT_BITS-1:0] count [NUM_LINES];
  logic [COUNT_BITS-1:0] count_next [NUM_LINES];

  // A command issues only when the result queue has a place for it and for
  // every command still in the pipeline, so the pipeline never stalls.
  assign head_pop = head.valid &&
                    (int'(res_level) + int'(s1_valid) + int'(s2_valid) < RESQ_DEPTH);

  always_ff @(posedge clk) begin
    if (head_pop) begin
      s1_last <= center_mem[head.cmd.slot];
      if (head.cmd.op == OP_UPDATE) begin
        center_mem[head.cmd.slot] <= head.cmd.center;
      end
    end
  end

  always_comb begin
    line_p[LINE_HORIZONTAL].x = '0;
    line_p[LINE_HORIZONTAL].y = CENTER_BITS'(frame_height >> 1);
    line_q[LINE_HORIZONTAL].x = CENTER_BITS'(frame_width);
    line_q[LINE_HORIZONTAL].y = CENTER_BITS'(frame_height >> 1);
    line_p[LINE_VERTICAL].x   = CENTER_BITS'(frame_width >> 1);
    line_p[LINE_VERTICAL].y   = '0;
    line_q[LINE_VERTICAL].x   = CENTER_BITS'(frame_width >> 1);
    line_q[LINE_VERTICAL].y   = CENTER_BITS'(frame_height);
    line_p[LINE_DIAGONAL].x   = '0;
    line_p[LINE_DIAGONAL].y   = '0;
    line_q[LINE_DIAGONAL].x   = CENTER_BITS'(frame_width);
    line_q[LINE_DIAGONAL].y   = CENTER_BITS'(frame_height);
  end

  // Orientation of (u, v, w): (v.y - u.y) * (w.x - v.x) - (v.x - u.x) * (w.y - v.y).
  // The four tests per line are (a, b, p), (a, b, q), (p, q, a) and (p, q, b).
  always_comb begin
    point_t u;
    point_t v;
    point_t w;
    logic signed [DIFF_BITS-1:0] dy1;
    logic signed [DIFF_BITS-1:0] dx2;
    logic signed [DIFF_BITS-1:0] dx1;
    logic signed [DIFF_BITS-1:0] dy2;
    for (int k = 0; k < NUM_LINES; k++) begin
      for (int j = 0; j < TURNS_PER_LINE; j++) begin
        case (j)
          0: begin
            u = s1_last;   v = s1_cmd.center; w = line_p[k];
          end
          1: begin
            u = s1_last;   v = s1_cmd.center; w = line_q[k];
          end
          2: begin
            u = line_p[k]; v = line_q[k];     w = s1_last;
          end
          default: begin
            u = line_p[k]; v = line_q[k];     w = s1_cmd.center;
          end
        endcase
        dy1 = coord_diff(v.y, u.y);
        dx2 = coord_diff(w.x, v.x);
        dx1 = coord_diff(v.x, u.x);
        dy2 = coord_diff(w.y, v.y);
        prod_l[k][j] = PROD_BITS'(dy1) * PROD_BITS'(dx2);
        prod_r[k][j] = PROD_BITS'(dx1) * PROD_BITS'(dy2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= head_pop;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      s1_cmd <= head.cmd;
    end
    if (s1_valid) begin
      s2_cmd    <= s1_cmd;
      s2_last   <= s1_last;
      s2_prod_l <= prod_l;
      s2_prod_r <= prod_r;
    end
  end

  assign test_en = s2_valid && s2_cmd.op == OP_UPDATE &&
                   known[s2_cmd.slot] && !counted[s2_cmd.slot];

  always_comb begin
    logic signed [TURN_BITS-1:0] t;
    for (int k = 0; k < NUM_LINES; k++) begin
      for (int j = 0; j < TURNS_PER_LINE; j++) begin
        t = TURN_BITS'(s2_prod_l[k][j]) - TURN_BITS'(s2_prod_r[k][j]);
        if (t == '0) begin
          turn[k][j] = TURN_FLAT;
        end else if (!t[TURN_BITS-1]) begin
          turn[k][j] = TURN_POS;
        end else begin
          turn[k][j] = TURN_NEG;
        end
      end
      // General crossing, or an endpoint lying on the other segment.
      hit[k] = test_en && (
        (turn[k][0] != turn[k][1] && turn[k][2] != turn[k][3]) ||
        (turn[k][0] == TURN_FLAT && in_box(s2_last, line_p[k], s2_cmd.center)) ||
        (turn[k][1] == TURN_FLAT && in_box(s2_last, line_q[k], s2_cmd.center)) ||
        (turn[k][2] == TURN_FLAT && in_box(line_p[k], s2_last, line_q[k])) ||
        (turn[k][3] == TURN_FLAT && in_box(line_p[k], s2_cmd.center, line_q[k])));
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      case (s2_cmd.op)
        OP_UPDATE: begin
          count_next[k] = (hit[k] && count[k] != '1) ? count[k] + COUNT_BITS'(1) : count[k];
        end
        OP_CLEAR: begin
          count_next[k] = '0;
        end
        default: begin
          count_next[k] = count[k];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known   <= '0;
      counted <= '0;
      for (int k = 0; k < NUM_LINES; k++) begin
        count[k] <= '0;
      end
    end else if (s2_valid) begin
      count <= count_next;
      case (s2_cmd.op)
        OP_UPDATE: begin
          known[s2_cmd.slot] <= 1'b1;
          if (hit != '0) begin
            counted[s2_cmd.slot] <= 1'b1;
          end
        end
        OP_FORGET: begin
          known[s2_cmd.slot] <= 1'b0;
        end
        OP_CLEAR: begin
          counted <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_push.valid                = s2_valid;
    res_push.res.hit_horizontal   = hit[LINE_HORIZONTAL];
    res_push.res.hit_vertical     = hit[LINE_VERTICAL];
    res_push.res.hit_diagonal     = hit[LINE_DIAGONAL];
    res_push.res.horizontal_total = count_next[LINE_HORIZONTAL];
    res_push.res.vertical_total   = count_next[LINE_VERTICAL];
    res_push.res.diagonal_total   = count_next[LINE_DIAGONAL];
  end

endmodule

>>> sv/lcc_outq.sv
// ----------------------------------------------------------------------------
// lcc_outq: result queue
// Holds finished results until the consumer pops them and reports its fill
// level so the back end can reserve places ahead of time.
// ----------------------------------------------------------------------------
module lcc_outq (
  input  logic                                clk,
  input  logic                                rst,
  input  lcc_pkg::res_push_t                  res_push,
  output logic                                empty,
  input  logic                                pop,
  output lcc_pkg::result_t                    result,
  output logic [lcc_pkg::RESQ_LEVEL_BITS-1:0] level
);
  import lcc_pkg::*;

  localparam int PTR_BITS = $clog2(RESQ_DEPTH);

  result_t                    queue [RESQ_DEPTH];
  logic [PTR_BITS-1:0]        wr_ptr;
  logic [PTR_BITS-1:0]        rd_ptr;
  logic [RESQ_LEVEL_BITS-1:0] level_next;
  logic                       rd_en;

  assign empty  = level == '0;
  assign rd_en  = pop && !empty;
  assign result = queue[rd_ptr];

  always_comb begin
    level_next = level;
    if (res_push.valid && !rd_en) begin
      level_next = level + RESQ_LEVEL_BITS'(1);
    end else if (rd_en && !res_push.valid) begin
      level_next = level - RESQ_LEVEL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      level <= level_next;
      if (res_push.valid) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push.valid) begin
      queue[wr_ptr] <= res_push.res;
    end
  end

endmodule

>>> verif/line_crossing_counter_core_tb.sv
// ----------------------------------------------------------------------------
// line_crossing_counter_core_tb: self-checking bench for the crossing counter
// Drives detection, forget, clear and no-op requests through the queue style
// ports, takes each result from its model of the slot table and three frame
// lines or a directed row, and compares each popped result field by field.
// Both sides stall at random, and the frame size is rewritten between phases.
// ----------------------------------------------------------------------------
module line_crossing_counter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcc_pkg::*;

  typedef struct {
    int x;
    int y;
  } xy_t;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  push = 1'b0;
  logic                  full;
  item_t                 item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = REG_FRAME_WIDTH;
  logic [FRAME_BITS-1:0] cfg_data = '0;

  // Model of the block's state.
  logic [FRAME_BITS-1:0]  frame_w;
  logic [FRAME_BITS-1:0]  frame_h;
  logic [CENTER_BITS-1:0] prev_x [MAX_TRACKS];
  logic [CENTER_BITS-1:0] prev_y [MAX_TRACKS];
  bit                     seen [MAX_TRACKS];
  bit                     tallied [MAX_TRACKS];
  logic [COUNT_BITS-1:0]  tally_h;
  logic [COUNT_BITS-1:0]  tally_v;
  logic [COUNT_BITS-1:0]  tally_d;

  result_t awaited [$];
  row_t    plan [$];
  int      errors = 0;
  bit      steady = 1'b0;

  line_crossing_counter_core uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic xy_t pt(int x, int y);
    xy_t p;
    p.x = x;
    p.y = y;
    return p;
  endfunction

  function automatic turn_t turn_dir(xy_t a, xy_t b, xy_t c);
    int v;
    v = (b.y - a.y) * (c.x - b.x) - (b.x - a.x) * (c.y - b.y);
    if (v == 0) return TURN_FLAT;
    return (v > 0) ? TURN_POS : TURN_NEG;
  endfunction

  // True when m lies in the bounding box spanned by a and c, edges included.
  function automatic bit in_span(xy_t a, xy_t m, xy_t c);
    return m.x >= ((a.x < c.x) ? a.x : c.x) && m.x <= ((a.x < c.x) ? c.x : a.x) &&
           m.y >= ((a.y < c.y) ? a.y : c.y) && m.y <= ((a.y < c.y) ? c.y : a.y);
  endfunction

  function automatic bit segments_cross(xy_t a, xy_t b, xy_t c, xy_t d);
    turn_t t1, t2, t3, t4;
    t1 = turn_dir(a, b, c);
    t2 = turn_dir(a, b, d);
    t3 = turn_dir(c, d, a);
    t4 = turn_dir(c, d, b);
    if (t1 != t2 && t3 != t4) return 1'b1;
    if (t1 == TURN_FLAT && in_span(a, c, b)) return 1'b1;
    if (t2 == TURN_FLAT && in_span(a, d, b)) return 1'b1;
    if (t3 == TURN_FLAT && in_span(c, a, d)) return 1'b1;
    if (t4 == TURN_FLAT && in_span(c, b, d)) return 1'b1;
    return 1'b0;
  endfunction

  // Applies one request to the model and returns the result it should give.
  // With 64 slots and counted flags cleared only together with the counts,
  // no count can climb past 64, so the saturation limit is out of reach.
  function automatic result_t track_crossings(item_t it);
    result_t r;
    xy_t     a, b;
    int      w, h, slot;
    bit      hh, hv, hd;
    hh = 1'b0;
    hv = 1'b0;
    hd = 1'b0;
    slot = it.track_id;
    w = frame_w;
    h = frame_h;
    case (op_t'(it.mode))
      OP_UPDATE: begin
        b.x = it.box_x + (it.box_w >> 1);
        b.y = it.box_y + (it.box_h >> 1);
        if (seen[slot] && !tallied[slot]) begin
          a.x = prev_x[slot];
          a.y = prev_y[slot];
          hh = segments_cross(a, b, pt(0, h / 2), pt(w, h / 2));
          hv = segments_cross(a, b, pt(w / 2, 0), pt(w / 2, h));
          hd = segments_cross(a, b, pt(0, 0), pt(w, h));
          if (hh && tally_h != '1) tally_h++;
          if (hv && tally_v != '1) tally_v++;
          if (hd && tally_d != '1) tally_d++;
          if (hh || hv || hd) tallied[slot] = 1'b1;
        end
        prev_x[slot] = CENTER_BITS'(b.x);
        prev_y[slot] = CENTER_BITS'(b.y);
        seen[slot] = 1'b1;
      end
      OP_FORGET: seen[slot] = 1'b0;
      OP_CLEAR: begin
        tally_h = '0;
        tally_v = '0;
        tally_d = '0;
        foreach (tallied[i]) tallied[i] = 1'b0;
      end
      default: ;
    endcase
    r.hit_horizontal   = hh;
    r.hit_vertical     = hv;
    r.hit_diagonal     = hd;
    r.horizontal_total = tally_h;
    r.vertical_total   = tally_v;
    r.diagonal_total   = tally_d;
    return r;
  endfunction

  function automatic item_t box(op_t m, int id, int x, int y, int w, int h);
    item_t it;
    it.mode     = m;
    it.track_id = TRACK_ID_BITS'(id);
    it.box_x    = COORD_BITS'(x);
    it.box_y    = COORD_BITS'(y);
    it.box_w    = COORD_BITS'(w);
    it.box_h    = COORD_BITS'(h);
    return it;
  endfunction

  function automatic void add_row(item_t it, bit typed = 1'b0, result_t want = '0);
    row_t r;
    r.stim  = it;
    r.typed = typed;
    r.want  = want;
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic [COORD_BITS-1:0] near_coord(int extent);
    int v;
    v = $urandom_range(extent + 8);
    return COORD_BITS'((v > 1023) ? 1023 : v);
  endfunction

  // Mostly detections of a few busy slots moving around the frame lines, with
  // some forgets, clears, no-ops and boxes anywhere in the coordinate range.
  function automatic item_t pick_request();
    item_t       it;
    int unsigned r;
    r = $urandom_range(99);
    it.mode = (r < 3) ? OP_CLEAR : (r < 10) ? OP_FORGET : (r < 14) ? OP_IDLE : OP_UPDATE;
    it.track_id = TRACK_ID_BITS'(($urandom_range(3) == 0) ? $urandom_range(63)
                                                          : $urandom_range(7));
    if ($urandom_range(3) == 0) begin
      it.box_x = COORD_BITS'($urandom_range(1023));
      it.box_y = COORD_BITS'($urandom_range(1023));
      it.box_w = COORD_BITS'($urandom_range(1023));
      it.box_h = COORD_BITS'($urandom_range(1023));
    end else begin
      it.box_x = near_coord(frame_w);
      it.box_y = near_coord(frame_h);
      it.box_w = COORD_BITS'($urandom_range(15));
      it.box_h = COORD_BITS'($urandom_range(15));
    end
    return it;
  endfunction

  task automatic send_request(item_t it, bit typed, result_t want);
    result_t r;
    while (!steady && $urandom_range(99) < 23) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    r = track_crossings(it);
    awaited.insert(awaited.size(), typed ? want : r);
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [FRAME_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_WIDTH) frame_w = val;
    else frame_h = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10) $display("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(negedge clk) pop <= steady || ($urandom_range(99) >= 23);

  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no request outstanding: %p", result);
      end else begin
        want = awaited[0];
        awaited.delete(0);
        check_field("hit_horizontal", want.hit_horizontal, result.hit_horizontal);
        check_field("hit_vertical", want.hit_vertical, result.hit_vertical);
        check_field("hit_diagonal", want.hit_diagonal, result.hit_diagonal);
        check_field("horizontal_total", want.horizontal_total, result.horizontal_total);
        check_field("vertical_total", want.vertical_total, result.vertical_total);
        check_field("diagonal_total", want.diagonal_total, result.diagonal_total);
      end
    end
  end

  initial begin
    int unsigned useful;
    item_t       it;
    rst = 1'b1;
    frame_w = FRAME_RESET;
    frame_h = FRAME_RESET;
    tally_h = '0;
    tally_v = '0;
    tally_d = '0;
    foreach (seen[i]) begin
      seen[i] = 1'b0;
      tallied[i] = 1'b0;
      prev_x[i] = '0;
      prev_y[i] = '0;
    end

    // Reset frame is 160 x 160: horizontal line at y 80, vertical at x 80,
    // diagonal from the origin to (160, 160).
    add_row(box(OP_UPDATE, 0, 0, 0, 0, 0), 1'b1, '0);
    add_row(box(OP_UPDATE, 0, 160, 0, 0, 0), 1'b1,
            {1'b0, 1'b1, 1'b1, 16'd0, 16'd1, 16'd1});
    // The slot is counted now, so no further test.
    add_row(box(OP_UPDATE, 0, 100, 100, 0, 0), 1'b1,
            {1'b0, 1'b0, 1'b0, 16'd0, 16'd1, 16'd1});
    add_row(box(OP_UPDATE, 1, 1023, 1023, 1023, 1023), 1'b1,
            {1'b0, 1'b0, 1'b0, 16'd0, 16'd1, 16'd1});
    add_row(box(OP_UPDATE, 1, 0, 1023, 1023, 0));
    add_row(box(OP_UPDATE, 1, 0, 0, 1, 1));
    // Movement along the horizontal line, then along the vertical line.
    add_row(box(OP_UPDATE, 2, 10, 80, 0, 0));
    add_row(box(OP_UPDATE, 2, 200, 80, 0, 0));
    add_row(box(OP_UPDATE, 3, 80, 0, 0, 0));
    add_row(box(OP_UPDATE, 3, 80, 160, 0, 0));
    // On the diagonal's extension but short of its end point.
    add_row(box(OP_UPDATE, 4, 200, 200, 0, 0));
    add_row(box(OP_UPDATE, 4, 161, 161, 0, 0));
    // Starting exactly on the diagonal's end point.
    add_row(box(OP_UPDATE, 5, 160, 160, 0, 0));
    add_row(box(OP_UPDATE, 5, 170, 170, 0, 0));
    // A forgotten position is not tested against the lines.
    add_row(box(OP_UPDATE, 6, 0, 50, 0, 0));
    add_row(box(OP_FORGET, 6, 1023, 1023, 1023, 1023));
    add_row(box(OP_UPDATE, 6, 160, 50, 0, 0));
    add_row(box(OP_IDLE, 63, 1023, 1023, 1023, 1023));
    add_row(box(OP_CLEAR, 63, 1023, 1023, 1023, 1023), 1'b1, '0);
    add_row(box(OP_IDLE, 0, 0, 0, 0, 0), 1'b1, '0);
    // Slot 0 keeps its position through the clear and may count again.
    add_row(box(OP_UPDATE, 0, 0, 0, 0, 0));
    add_row(box(OP_UPDATE, 63, 1023, 1023, 0, 0));
    add_row(box(OP_FORGET, 63, 0, 0, 0, 0));
    add_row(box(OP_UPDATE, 63, 0, 0, 1023, 1023));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            write_reg(REG_FRAME_WIDTH, 10'd1023);
            write_reg(REG_FRAME_HEIGHT, 10'd1023);
          end
          2: begin
            write_reg(REG_FRAME_WIDTH, 10'd1);
            write_reg(REG_FRAME_HEIGHT, 10'd1);
          end
          3: begin
            write_reg(REG_FRAME_WIDTH, 10'd0);
            write_reg(REG_FRAME_HEIGHT, 10'd1023);
          end
          4: begin
            write_reg(REG_FRAME_WIDTH, 10'd1023);
            write_reg(REG_FRAME_HEIGHT, 10'd0);
          end
          default: begin
            write_reg(REG_FRAME_WIDTH, FRAME_BITS'($urandom_range(1023, 1)));
            write_reg(REG_FRAME_HEIGHT, FRAME_BITS'($urandom_range(1023, 1)));
          end
        endcase
      end else begin
        foreach (plan[i]) send_request(plan[i].stim, plan[i].typed, plan[i].want);
      end
      // One whole phase runs with neither side stalling.
      steady = (ph == 2);
      useful = 0;
      while (useful < 315) begin
        it = pick_request();
        send_request(it, 1'b0, '0);
        if (op_t'(it.mode) != OP_IDLE) useful++;
      end
      steady = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
